FILE: hdl/lsru_pkg.sv
// ----------------------------------------------------------------------------
// lsru_pkg
// Shared types and constants for the load/store register unit.
// ----------------------------------------------------------------------------
package lsru_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int REG_COUNT_DEF = 32;

  localparam int LANES = 4;

  typedef enum logic [3:0] {
    FN_LW     = 4'd0,
    FN_LH     = 4'd1,
    FN_LHU    = 4'd2,
    FN_LB     = 4'd3,
    FN_LBU    = 4'd4,
    FN_SW     = 4'd5,
    FN_SH     = 4'd6,
    FN_SB     = 4'd7,
    FN_REG_WR = 4'd8,
    FN_REG_RD = 4'd9
  } func_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_RANGE  = 2'd1,
    STS_BADREG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch a new item
    logic exec_go;    // finish a non-load item: commit writes, post result
    logic mem_rd;     // issue the load read to the byte lanes
    logic load_done;  // write back the load, post result
  } lsru_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_go;    // item is a legal, in-range load
    logic out_free;   // result register can take a result this cycle
  } lsru_sts_t;

endpackage

FILE: hdl/load_store_register_unit.sv
// ----------------------------------------------------------------------------
// load_store_register_unit
// Byte-addressed little-endian data memory plus a 32-bit register file.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on the s-side stream is one operation (loads, stores,
//   register write, register read); each produces exactly one result item
//   on the m-side stream carrying read_data and a status code.
//   in_tready is high while the unit is idle and out of reset. The result
//   of a non-load is registered from the EXEC state; a load first passes
//   through EXEC, where the four byte-lane RAMs are read (registered), and
//   then LOAD, where it is written back and its result registered. One item
//   is in flight at a time: the next is taken only after this result posts.
//   Results sit in an output register. A new item is taken while an older
//   result still waits; if the receiver stalls, the next item holds before
//   its write-back/result until the output register is free.
//   Reset clears the register file and the control state; data memory
//   contents are undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
module load_store_register_unit
  import lsru_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] func, [35:4] address, [40:36] reg_index, [72:41] write_value
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] read_data, [33:32] status
  output logic [39:0] out_tdata
);

  lsru_cmd_t   cmd;
  lsru_sts_t   sts;
  logic [31:0] read_data;
  logic [1:0]  status;

  lsru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsru_dp #(
    .MEM_BYTES(MEM_BYTES),
    .REG_COUNT(REG_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_tdata[3:0]),
    .in_address    (in_tdata[35:4]),
    .in_reg_index  (in_tdata[40:36]),
    .in_write_value(in_tdata[72:41]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_read_data (read_data),
    .out_status    (status)
  );

  assign out_tdata = {6'd0, status, read_data};

endmodule

FILE: hdl/lsru_ram.sv
// ----------------------------------------------------------------------------
// lsru_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/lsru_ctrl.sv
// ----------------------------------------------------------------------------
// lsru_ctrl
// Sequencer: accept, execute, optional load write-back.
// ----------------------------------------------------------------------------
module lsru_ctrl
  import lsru_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lsru_sts_t sts,
  output lsru_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.load_go)       state_nxt = ST_LOAD;
        else if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_LOAD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // no item is taken while reset is held
  always_comb begin
    in_tready     = (state_r == ST_IDLE) && rst_n;
    cmd.capture   = (state_r == ST_IDLE) && rst_n && in_tvalid;
    cmd.mem_rd    = (state_r == ST_EXEC) && sts.load_go;
    cmd.exec_go   = (state_r == ST_EXEC) && !sts.load_go && sts.out_free;
    cmd.load_done = (state_r == ST_LOAD) && sts.out_free;
  end

endmodule

FILE: hdl/lsru_dp.sv
// ----------------------------------------------------------------------------
// lsru_dp
// Datapath: item registers, checks, register file, four byte-lane RAMs,
// load alignment and the result register.
// ----------------------------------------------------------------------------
module lsru_dp
  import lsru_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lsru_cmd_t   cmd,
  output lsru_sts_t   sts,
  input  logic [3:0]  in_func,
  input  logic [31:0] in_address,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_status
);

  localparam int ROWS  = (MEM_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RIW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // item registers
  logic [3:0]  func_r;
  logic [31:0] addr_r;
  logic [4:0]  reg_r;
  logic [31:0] wval_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      addr_r <= in_address;
      reg_r  <= in_reg_index;
      wval_r <= in_write_value;
    end
  end

  // checks
  logic [1:0]  size_m1;
  logic [32:0] last_byte;
  logic        range_ok, bad_reg, is_load, is_store, is_mem;
  status_t     exec_status;

  always_comb begin
    unique case (func_r)
      FN_LW, FN_SW:         size_m1 = 2'd3;
      FN_LH, FN_LHU, FN_SH: size_m1 = 2'd1;
      default:              size_m1 = 2'd0;
    endcase
    last_byte = {1'b0, addr_r} + 33'(size_m1);
    range_ok  = last_byte < 33'(MEM_BYTES);
    is_load   = func_r <= FN_LBU;
    is_mem    = func_r <= FN_SB;
    is_store  = is_mem && !is_load;
    bad_reg   = (func_r <= FN_REG_RD) && ({1'b0, reg_r} >= 6'(REG_COUNT));

    priority if (bad_reg)                             exec_status = STS_BADREG;
    else if (is_mem && !range_ok)                     exec_status = STS_RANGE;
    else if (func_r == FN_REG_WR && reg_r == 5'd0)    exec_status = STS_BADREG;
    else                                              exec_status = STS_OK;
  end

  // register file; entry zero is never written, so it always reads zero
  logic [31:0] rf_r [REG_COUNT];
  logic [31:0] rf_rd;
  logic [31:0] load_val;
  logic        rf_we;
  logic [31:0] rf_wdata;

  assign rf_rd = rf_r[reg_r[RIW-1:0]];

  always_comb begin
    rf_we    = 1'b0;
    rf_wdata = load_val;
    if (cmd.load_done && reg_r != 5'd0) begin
      rf_we = 1'b1;
    end else if (cmd.exec_go && func_r == FN_REG_WR && exec_status == STS_OK) begin
      rf_we    = 1'b1;
      rf_wdata = wval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= '0;
    end else if (rf_we) begin
      rf_r[reg_r[RIW-1:0]] <= rf_wdata;
    end
  end

  // byte lanes: byte k of an access sits in lane (offset + k) mod 4, in the
  // base row or, for lanes below the offset, in the row after it
  logic [1:0]       off;
  logic [ROW_W-1:0] row_base;
  logic [1:0]       lane_k   [LANES];
  logic [ROW_W-1:0] lane_row [LANES];
  logic [LANES-1:0] lane_we;
  logic [7:0]       lane_wd  [LANES];
  logic [7:0]       lane_q   [LANES];

  assign off      = addr_r[1:0];
  assign row_base = addr_r[ROW_W+1:2];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_k[l]   = 2'(l) - off;
      lane_row[l] = row_base + ROW_W'(2'(l) < off);
      lane_we[l]  = cmd.exec_go && is_store && exec_status == STS_OK &&
                    (lane_k[l] <= size_m1);
      lane_wd[l]  = rf_rd[8*lane_k[l] +: 8];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lsru_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .en   (cmd.mem_rd || lane_we[g]),
      .we   (lane_we[g]),
      .addr (lane_row[g]),
      .wdata(lane_wd[g]),
      .rdata(lane_q[g])
    );
  end

  // load alignment and extension
  logic [31:0] raw;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      raw[8*k +: 8] = lane_q[2'(off + 2'(k))];
    end
    unique case (func_r)
      FN_LW:   load_val = raw;
      FN_LH:   load_val = {{16{raw[15]}}, raw[15:0]};
      FN_LHU:  load_val = {16'd0, raw[15:0]};
      FN_LB:   load_val = {{24{raw[7]}}, raw[7:0]};
      default: load_val = {24'd0, raw[7:0]};
    endcase
  end

  // result register
  logic        out_valid_r;
  logic [31:0] out_rdata_r;
  logic [1:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec_go || cmd.load_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_done) begin
      out_rdata_r  <= '0;
      out_status_r <= STS_OK;
    end else if (cmd.exec_go) begin
      out_rdata_r  <= (func_r == FN_REG_RD && !bad_reg) ? rf_rd : 32'd0;
      out_status_r <= exec_status;
    end
  end

  assign sts.load_go  = is_load && !bad_reg && range_ok;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rdata_r;
  assign out_status    = out_status_r;

endmodule

FILE: test/tb_load_store_register_unit.sv
// ----------------------------------------------------------------------------
// tb_load_store_register_unit
// Drives load, store and register operations into the unit and compares each
// result item against a local model of the memory and register file.
// ----------------------------------------------------------------------------
module tb_load_store_register_unit;
  import lsru_pkg::*;

  localparam int MEMB        = MEM_BYTES_DEF;
  localparam int REGN        = REG_COUNT_DEF;
  localparam int STALL_LIMIT = 3000;

  // func codes the unit ignores
  localparam logic [3:0] FN_UNUSED_LO = 4'd10;
  localparam logic [3:0] FN_UNUSED_HI = 4'd15;

  typedef struct {
    logic [3:0]  fn;
    logic [31:0] addr;
    logic [4:0]  ridx;
    logic [31:0] wval;
  } lsu_op_t;

  typedef struct {
    logic [31:0] rdata;
    status_t     sts;
  } lsu_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [3:0] func, [35:4] address, [40:36] reg_index, [72:41] write_value
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [31:0] read_data, [33:32] status
  logic [39:0] out_tdata;

  // model state
  logic [7:0]  mem_img [0:MEMB-1];
  bit          mem_known [0:MEMB-1];
  logic [31:0] reg_img [0:REGN-1];
  int          recent_stores[$];
  lsu_res_t    due_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int rx_hold_left;
  int quiet_cycles;
  int results_seen;
  int error_count;

  load_store_register_unit #(
    .MEM_BYTES(MEMB),
    .REG_COUNT(REGN)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  function automatic int access_bytes(input logic [3:0] fn);
    case (fn)
      FN_LW, FN_SW:          return 4;
      FN_LH, FN_LHU, FN_SH:  return 2;
      FN_LB, FN_LBU, FN_SB:  return 1;
      default:               return 0;
    endcase
  endfunction

  // address whose access runs past the end of memory
  function automatic logic [31:0] beyond_end(input int nbytes);
    if ($urandom_range(0, 1) != 0) return $urandom | 32'(MEMB);
    return 32'(MEMB - nbytes + int'($urandom_range(1, 3)));
  endfunction

  function automatic lsu_op_t mk_op(input logic [3:0] fn, input logic [31:0] addr,
                                    input logic [4:0] ridx, input logic [31:0] wval);
    lsu_op_t op;
    op.fn   = fn;
    op.addr = addr;
    op.ridx = ridx;
    op.wval = wval;
    return op;
  endfunction

  // executes one operation on the local state and returns its result item
  function automatic lsu_res_t apply_op(input lsu_op_t op);
    lsu_res_t    r;
    int          nbytes;
    bit          in_mem;
    logic [31:0] v;
    r.rdata = '0;
    r.sts   = STS_OK;
    v       = '0;
    nbytes  = access_bytes(op.fn);
    in_mem  = ({32'b0, op.addr} + 64'(nbytes)) <= 64'(MEMB);
    if (op.fn <= FN_REG_RD && int'(op.ridx) >= REGN) begin
      r.sts = STS_BADREG;
    end else begin
      case (op.fn)
        FN_LW, FN_LH, FN_LHU, FN_LB, FN_LBU: begin
          if (!in_mem) begin
            r.sts = STS_RANGE;
          end else begin
            for (int i = 0; i < nbytes; i++) v[8*i +: 8] = mem_img[op.addr + i];
            if (op.fn == FN_LH) v = {{16{v[15]}}, v[15:0]};
            if (op.fn == FN_LB) v = {{24{v[7]}}, v[7:0]};
            // loads into r0 are dropped
            if (op.ridx != 0) reg_img[op.ridx] = v;
          end
        end
        FN_SW, FN_SH, FN_SB: begin
          if (!in_mem) begin
            r.sts = STS_RANGE;
          end else begin
            for (int i = 0; i < nbytes; i++) begin
              mem_img[op.addr + i]   = reg_img[op.ridx][8*i +: 8];
              mem_known[op.addr + i] = 1'b1;
            end
            recent_stores.push_back(int'(op.addr));
            if (recent_stores.size() > 64) recent_stores.delete(0);
          end
        end
        FN_REG_WR: begin
          if (op.ridx == 0) r.sts = STS_BADREG;
          else reg_img[op.ridx] = op.wval;
        end
        FN_REG_RD: r.rdata = reg_img[op.ridx];
        default: ;
      endcase
    end
    return r;
  endfunction

  // loads only touch bytes already written; otherwise the item becomes a store
  function automatic lsu_op_t random_op();
    lsu_op_t op;
    int      pick;
    int      nbytes;
    int      a;
    bit      found;
    op.fn   = FN_REG_RD;
    op.addr = $urandom;
    op.ridx = 5'($urandom_range(0, 31));
    op.wval = $urandom;
    pick    = $urandom_range(0, 99);
    if (pick < 12) op.fn = FN_REG_WR;
    else if (pick < 24) op.fn = FN_REG_RD;
    else if (pick < 54) op.fn = 4'($urandom_range(int'(FN_SW), int'(FN_SB)));
    else if (pick < 93) op.fn = 4'($urandom_range(int'(FN_LW), int'(FN_LBU)));
    else op.fn = 4'($urandom_range(int'(FN_UNUSED_LO), int'(FN_UNUSED_HI)));
    nbytes = access_bytes(op.fn);

    if (op.fn <= FN_LBU) begin
      if ($urandom_range(0, 9) == 0) begin
        op.addr = beyond_end(nbytes);
      end else begin
        found = 1'b0;
        a     = -1;
        for (int t = 0; t < 8 && !found; t++) begin
          case ($urandom_range(0, 3))
            0, 1: a = $urandom_range(0, 255);
            2:    a = MEMB - int'($urandom_range(1, 64));
            default: begin
              if (recent_stores.size() != 0)
                a = recent_stores[$urandom_range(0, recent_stores.size() - 1)]
                    + int'($urandom_range(0, 6)) - 3;
              else
                a = -1;
            end
          endcase
          found = (a >= 0) && (a + nbytes <= MEMB);
          for (int i = 0; found && i < nbytes; i++) found = mem_known[a + i];
        end
        if (found) op.addr = 32'(a);
        else op.fn = (nbytes == 4) ? FN_SW : (nbytes == 2) ? FN_SH : FN_SB;
      end
    end

    if (op.fn >= FN_SW && op.fn <= FN_SB) begin
      case ($urandom_range(0, 9))
        0:       op.addr = beyond_end(nbytes);
        1, 2:    op.addr = 32'(MEMB - nbytes - int'($urandom_range(0, 60)));
        3:       op.addr = $urandom_range(0, MEMB - nbytes);
        default: op.addr = $urandom_range(0, 255);
      endcase
    end
    return op;
  endfunction

  task automatic issue_op(input lsu_op_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, op.wval, op.ridx, op.addr, op.fn};
    do @(posedge clk); while (!in_tready);
    due_results.push_back(apply_op(op));
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_register_ops();
    issue_op(mk_op(FN_REG_WR, 32'h0000_0000, 5'd1, 32'hFFFF_FFFF));
    issue_op(mk_op(FN_REG_WR, 32'hFFFF_FFFF, 5'd2, 32'h8000_7F80));
    issue_op(mk_op(FN_REG_WR, 32'h0000_0000, 5'd0, 32'h1234_5678));
    issue_op(mk_op(FN_REG_RD, 32'h0000_0000, 5'd0, 32'h0000_0000));
    issue_op(mk_op(FN_REG_RD, 32'h0000_0000, 5'd1, 32'h0000_0000));
    wait_results_drained();
  endtask

  task automatic test_memory_edges();
    issue_op(mk_op(FN_SW, 32'd0, 5'd2, '0));
    issue_op(mk_op(FN_SW, 32'(MEMB - 4), 5'd1, '0));
    issue_op(mk_op(FN_SW, 32'(MEMB - 3), 5'd1, '0));
    issue_op(mk_op(FN_SH, 32'(MEMB - 2), 5'd2, '0));
    issue_op(mk_op(FN_SB, 32'(MEMB - 1), 5'd2, '0));
    issue_op(mk_op(FN_SB, 32'(MEMB), 5'd1, '0));
    // last byte would wrap to address 2 if computed in 32 bits
    issue_op(mk_op(FN_SW, 32'hFFFF_FFFF, 5'd1, '0));
    issue_op(mk_op(FN_LW, 32'd0, 5'd3, '0));
    issue_op(mk_op(FN_LH, 32'd2, 5'd4, '0));
    issue_op(mk_op(FN_LHU, 32'd2, 5'd5, '0));
    issue_op(mk_op(FN_LB, 32'd0, 5'd6, '0));
    issue_op(mk_op(FN_LBU, 32'd0, 5'd7, '0));
    issue_op(mk_op(FN_LB, 32'd1, 5'd8, '0));
    issue_op(mk_op(FN_LH, 32'(MEMB - 2), 5'd9, '0));
    issue_op(mk_op(FN_LW, 32'd0, 5'd0, '0));
    issue_op(mk_op(FN_REG_RD, 32'd0, 5'd0, '0));
    // r0 as store source writes zeros
    issue_op(mk_op(FN_SW, 32'd4, 5'd0, '0));
    issue_op(mk_op(FN_LW, 32'd4, 5'd10, '0));
    issue_op(mk_op(FN_LH, 32'(MEMB - 1), 5'd11, '0));
    wait_results_drained();
  endtask

  task automatic test_unknown_funcs();
    issue_op(mk_op(FN_UNUSED_LO, 32'd0, 5'd1, 32'hDEAD_BEEF));
    issue_op(mk_op(FN_UNUSED_HI, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int count, input int tx_idle, input int rx_idle);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    repeat (count) issue_op(random_op());
    wait_results_drained();
  endtask

  // receiver goes quiet long enough for the unit to back up into the input
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold_left  = 300;
    repeat (40) issue_op(random_op());
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    lsu_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item, tdata %h", out_tdata));
      end else begin
        want = due_results.pop_front();
        if (out_tdata[31:0] !== want.rdata)
          report_mismatch($sformatf("read_data %h, expected %h", out_tdata[31:0], want.rdata));
        if (out_tdata[33:32] !== want.sts)
          report_mismatch($sformatf("status %0d, expected %0d", out_tdata[33:32], want.sts));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_load_store_register_unit: done, errors");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 45;
    rx_hold_left  = 0;
    quiet_cycles  = 0;
    results_seen  = 0;
    error_count   = 0;
    foreach (reg_img[i]) reg_img[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_ops();
    test_memory_edges();
    test_unknown_funcs();
    test_random_traffic(630, 19, 45);
    test_output_stall();
    test_random_traffic(630, 45, 19);
    test_random_traffic(630, 0, 0);

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d items never returned", due_results.size()));

    if (error_count == 0) begin
      $display("tb_load_store_register_unit: done, clean");
    end else begin
      $display("tb_load_store_register_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lsru_pkg.sv
hdl/lsru_ram.sv
hdl/lsru_ctrl.sv
hdl/lsru_dp.sv
hdl/load_store_register_unit.sv
test/tb_load_store_register_unit.sv
